@@ src/tcce_pkg.sv @@
package tcce_pkg;

  // default screen geometry
  localparam int COLUMNS_DEF = 80;
  localparam int ROWS_DEF    = 25;

  // fixed field widths of the stream payloads
  localparam int OP_W        = 2;
  localparam int CHAR_W      = 8;
  localparam int IDX_IN_W    = 11;
  localparam int ROW_OUT_W   = 5;
  localparam int COL_OUT_W   = 7;
  localparam int POS_OUT_W   = 11;
  localparam int IN_TDATA_W  = 24;
  localparam int OUT_TDATA_W = 40;

  // operation codes
  localparam logic [OP_W-1:0] OP_PUT   = 2'd0;
  localparam logic [OP_W-1:0] OP_CLEAR = 2'd1;
  localparam logic [OP_W-1:0] OP_READ  = 2'd2;

  // special bytes and reset attribute
  localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'h08;
  localparam logic [CHAR_W-1:0] CH_SPACE     = 8'h20;
  localparam logic [CHAR_W-1:0] RESET_COLOR  = 8'h07;

  typedef struct packed {
    logic [CHAR_W-1:0] color;
    logic [CHAR_W-1:0] code;
  } cell_t;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_READ,
    ST_SCROLL,
    ST_BLANK
  } state_t;

endpackage

@@ src/tcce_screen_ram.sv @@
module tcce_screen_ram #(
  parameter int DEPTH  = tcce_pkg::COLUMNS_DEF * tcce_pkg::ROWS_DEF,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [ADDR_W-1:0]    waddr,
  input  tcce_pkg::cell_t      wdata,
  input  logic                 re,
  input  logic [ADDR_W-1:0]    raddr,
  output tcce_pkg::cell_t      rdata
);

  tcce_pkg::cell_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ src/text_console_char_engine.sv @@
// Character-cell text console: a ROWS x COLUMNS screen memory of {attribute, character}
// cells plus a cursor. in_tuser selects put, clear or read; every transfer in gives one
// result transfer out carrying the cursor, its linear position and, for a read, the cell.
// Timing is set by the single-port-write screen memory: a put that does not scroll is
// written and answered as it is taken, a read waits in ST_READ for the registered memory
// output, a clear blanks every cell in ST_BLANK, and a put that scrolls copies every cell
// up one row in ST_SCROLL and then blanks the bottom row in ST_BLANK, one cell per cycle.
// After reset a clearing pass over all cells runs before in_tready first rises; cfg writes
// are taken during that pass. A new transfer is taken while the previous result waits
// in the output register as long as that result leaves in the same cycle.
module text_console_char_engine #(
  parameter int COLUMNS = tcce_pkg::COLUMNS_DEF,
  parameter int ROWS    = tcce_pkg::ROWS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_wr_en,
  input  logic [tcce_pkg::CHAR_W-1:0]         cfg_wr_data,   // text_color
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [tcce_pkg::IN_TDATA_W-1:0]     in_tdata,      // char_code, cell_index, pad
  input  logic [tcce_pkg::OP_W-1:0]           in_tuser,      // operation
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // cursor_row, cursor_col, cursor_pos, scrolled, cell_char, cell_color
  output logic [tcce_pkg::OUT_TDATA_W-1:0]    out_tdata
);

  localparam int CELL_COUNT = ROWS * COLUMNS;
  localparam int CELL_W     = $clog2(CELL_COUNT);
  localparam int COL_W      = $clog2(COLUMNS);
  localparam int ROW_W      = $clog2(ROWS);
  localparam int MOVE_N     = CELL_COUNT - COLUMNS;
  localparam int IDX_W      = ((CELL_W > tcce_pkg::IDX_IN_W) ? CELL_W : tcce_pkg::IDX_IN_W) + 1;

  localparam logic [CELL_W-1:0] LAST_CELL = CELL_W'(CELL_COUNT - 1);
  localparam logic [CELL_W-1:0] MOVE_END  = CELL_W'(MOVE_N);
  localparam logic [CELL_W-1:0] COLS_C    = CELL_W'(COLUMNS);
  localparam logic [CELL_W-1:0] LROW_POS  = CELL_W'(MOVE_N);
  localparam logic [COL_W-1:0]  LAST_COL  = COL_W'(COLUMNS - 1);
  localparam logic [ROW_W-1:0]  LAST_ROW  = ROW_W'(ROWS - 1);

  tcce_pkg::state_t state_r, state_nxt;

  logic [CELL_W-1:0]            cnt_r, cnt_nxt;
  logic [ROW_W-1:0]             row_r, row_nxt;
  logic [COL_W-1:0]             col_r, col_nxt;
  logic [CELL_W-1:0]            pos_r, pos_nxt;
  logic [tcce_pkg::CHAR_W-1:0]  color_r;
  logic [tcce_pkg::CHAR_W-1:0]  blank_color_r, blank_color_nxt;
  logic                         scroll_pend_r, scroll_pend_nxt;
  logic                         rd_ok_r, rd_ok_nxt;
  logic                         out_valid_r;
  logic [tcce_pkg::OUT_TDATA_W-1:0] out_data_r;

  logic                         load_out;
  logic                         res_scrolled;
  tcce_pkg::cell_t              res_cell;

  logic                         mem_we;
  logic [CELL_W-1:0]            mem_waddr;
  tcce_pkg::cell_t              mem_wdata;
  logic                         mem_re;
  logic [CELL_W-1:0]            mem_raddr;
  tcce_pkg::cell_t              mem_rdata;

  // input decode
  logic                         in_fire;
  logic [tcce_pkg::OP_W-1:0]    in_op;
  logic [tcce_pkg::CHAR_W-1:0]  in_char;
  logic [tcce_pkg::IDX_IN_W-1:0] in_idx;
  logic [IDX_W-1:0]             idx_ext;
  logic                         idx_in_range;
  logic                         is_nl;
  logic                         is_bs;
  logic                         at_last_row;
  logic                         at_last_col;
  logic                         put_scroll;

  assign in_op   = in_tuser;
  assign in_char = in_tdata[7:0];
  assign in_idx  = in_tdata[18:8];
  assign idx_ext = IDX_W'(in_idx);
  assign idx_in_range = idx_ext < IDX_W'(CELL_COUNT);

  assign in_tready = (state_r == tcce_pkg::ST_IDLE) && (!out_valid_r || out_tready);
  assign in_fire   = in_tvalid && in_tready;

  assign is_nl       = in_char == tcce_pkg::CH_NEWLINE;
  assign is_bs       = in_char == tcce_pkg::CH_BACKSPACE;
  assign at_last_row = row_r == LAST_ROW;
  assign at_last_col = col_r == LAST_COL;
  assign put_scroll  = (in_op == tcce_pkg::OP_PUT) && at_last_row &&
                       (is_nl || (!is_bs && at_last_col));

  tcce_screen_ram #(
    .DEPTH  (CELL_COUNT),
    .ADDR_W (CELL_W)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      tcce_pkg::ST_INIT: begin
        if (cnt_r == LAST_CELL) state_nxt = tcce_pkg::ST_IDLE;
      end
      tcce_pkg::ST_IDLE: begin
        if (in_fire) begin
          if (put_scroll) begin
            state_nxt = tcce_pkg::ST_SCROLL;
          end else if (in_op == tcce_pkg::OP_CLEAR) begin
            state_nxt = tcce_pkg::ST_BLANK;
          end else if (in_op == tcce_pkg::OP_READ) begin
            state_nxt = tcce_pkg::ST_READ;
          end
        end
      end
      tcce_pkg::ST_READ: state_nxt = tcce_pkg::ST_IDLE;
      tcce_pkg::ST_SCROLL: begin
        if (cnt_r == MOVE_END) state_nxt = tcce_pkg::ST_BLANK;
      end
      tcce_pkg::ST_BLANK: begin
        if (cnt_r == LAST_CELL) state_nxt = tcce_pkg::ST_IDLE;
      end
      default: state_nxt = tcce_pkg::ST_IDLE;
    endcase
  end

  // datapath and memory control
  always_comb begin
    cnt_nxt         = cnt_r;
    row_nxt         = row_r;
    col_nxt         = col_r;
    pos_nxt         = pos_r;
    blank_color_nxt = blank_color_r;
    scroll_pend_nxt = scroll_pend_r;
    rd_ok_nxt       = rd_ok_r;
    load_out        = 1'b0;
    res_scrolled    = 1'b0;
    res_cell        = '0;
    mem_we          = 1'b0;
    mem_waddr       = cnt_r;
    mem_wdata       = '{color: blank_color_r, code: tcce_pkg::CH_SPACE};
    mem_re          = 1'b0;
    mem_raddr       = CELL_W'(cnt_r + COLS_C);

    unique case (state_r)
      tcce_pkg::ST_INIT: begin
        mem_we    = 1'b1;
        mem_wdata = '{color: tcce_pkg::RESET_COLOR, code: tcce_pkg::CH_SPACE};
        cnt_nxt   = (cnt_r == LAST_CELL) ? '0 : CELL_W'(cnt_r + 1'b1);
      end
      tcce_pkg::ST_IDLE: begin
        if (in_fire) begin
          cnt_nxt         = '0;
          blank_color_nxt = color_r;
          unique case (in_op)
            tcce_pkg::OP_PUT: begin
              if (is_nl) begin
                col_nxt = '0;
                if (at_last_row) begin
                  pos_nxt = LROW_POS;
                end else begin
                  row_nxt = ROW_W'(row_r + 1'b1);
                  pos_nxt = CELL_W'(pos_r - CELL_W'(col_r) + COLS_C);
                end
              end else if (is_bs) begin
                if (col_r != '0) begin
                  col_nxt = COL_W'(col_r - 1'b1);
                  pos_nxt = CELL_W'(pos_r - 1'b1);
                end else if (row_r != '0) begin
                  row_nxt = ROW_W'(row_r - 1'b1);
                  col_nxt = LAST_COL;
                  pos_nxt = CELL_W'(pos_r - 1'b1);
                end
                mem_we    = 1'b1;
                mem_waddr = pos_nxt;
                mem_wdata = '{color: color_r, code: tcce_pkg::CH_SPACE};
              end else begin
                mem_we    = 1'b1;
                mem_waddr = pos_r;
                mem_wdata = '{color: color_r, code: in_char};
                if (at_last_col) begin
                  col_nxt = '0;
                  if (at_last_row) begin
                    pos_nxt = LROW_POS;
                  end else begin
                    row_nxt = ROW_W'(row_r + 1'b1);
                    pos_nxt = CELL_W'(pos_r + 1'b1);
                  end
                end else begin
                  col_nxt = COL_W'(col_r + 1'b1);
                  pos_nxt = CELL_W'(pos_r + 1'b1);
                end
              end
              scroll_pend_nxt = put_scroll;
              load_out        = !put_scroll;
            end
            tcce_pkg::OP_CLEAR: begin
              row_nxt         = '0;
              col_nxt         = '0;
              pos_nxt         = '0;
              scroll_pend_nxt = 1'b0;
            end
            tcce_pkg::OP_READ: begin
              mem_re    = idx_in_range;
              mem_raddr = idx_ext[CELL_W-1:0];
              rd_ok_nxt = idx_in_range;
            end
            default: begin
              load_out = 1'b1;
            end
          endcase
        end
      end
      tcce_pkg::ST_READ: begin
        load_out = 1'b1;
        if (rd_ok_r) res_cell = mem_rdata;
      end
      tcce_pkg::ST_SCROLL: begin
        // read one row ahead, write back what the previous cycle read
        mem_re    = cnt_r != MOVE_END;
        mem_we    = cnt_r != '0;
        mem_waddr = CELL_W'(cnt_r - 1'b1);
        mem_wdata = mem_rdata;
        if (cnt_r != MOVE_END) cnt_nxt = CELL_W'(cnt_r + 1'b1);
      end
      tcce_pkg::ST_BLANK: begin
        mem_we  = 1'b1;
        cnt_nxt = CELL_W'(cnt_r + 1'b1);
        if (cnt_r == LAST_CELL) begin
          load_out     = 1'b1;
          res_scrolled = scroll_pend_r;
        end
      end
      default: begin
        cnt_nxt = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= tcce_pkg::ST_INIT;
      cnt_r         <= '0;
      row_r         <= '0;
      col_r         <= '0;
      pos_r         <= '0;
      color_r       <= tcce_pkg::RESET_COLOR;
      scroll_pend_r <= 1'b0;
      rd_ok_r       <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      cnt_r         <= cnt_nxt;
      row_r         <= row_nxt;
      col_r         <= col_nxt;
      pos_r         <= pos_nxt;
      scroll_pend_r <= scroll_pend_nxt;
      rd_ok_r       <= rd_ok_nxt;
      if (cfg_wr_en) color_r <= cfg_wr_data;
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    blank_color_r <= blank_color_nxt;
    if (load_out) begin
      out_data_r <= {res_cell.color, res_cell.code, res_scrolled,
                     tcce_pkg::POS_OUT_W'(pos_nxt),
                     tcce_pkg::COL_OUT_W'(col_nxt),
                     tcce_pkg::ROW_OUT_W'(row_nxt)};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // cursor position always matches row and column
  a_pos_consistent: assert property (@(posedge clk) disable iff (!rst_n)
    (int'(pos_r) == int'(row_r) * COLUMNS + int'(col_r)))
    else $error("cursor position out of step with row and column");

  a_cursor_bounds: assert property (@(posedge clk) disable iff (!rst_n)
    (int'(row_r) < ROWS) && (int'(col_r) < COLUMNS))
    else $error("cursor outside the screen");

  // a new result never overwrites one that has not been taken
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    load_out |-> (!out_valid_r || out_tready))
    else $error("result register overrun");

  // the screen memory is only written by an accepted transfer or a sweep
  a_write_source: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> (in_fire || state_r != tcce_pkg::ST_IDLE))
    else $error("screen write without a transfer");

  a_read_range: assert property (@(posedge clk) disable iff (!rst_n)
    mem_re |-> (int'(mem_raddr) < CELL_COUNT))
    else $error("screen read beyond the last cell");

endmodule
